### rtl/tcw_pkg.sv
// ============================================================================
// tcw_pkg: shared types and constants of the console character writer
// Item kinds, grid defaults, field widths, control character codes, tab constants and sequencer states.
// ============================================================================
`default_nettype none

package tcw_pkg;

    // default grid size
    localparam int GRID_ROWS_DEF = 512;
    localparam int GRID_COLS_DEF = 256;

    // stream field widths
    localparam int KIND_W     = 2;
    localparam int CHAR_W     = 8;
    localparam int RROW_W     = 9;
    localparam int RCOL_W     = 8;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 32;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // control characters
    localparam logic [CHAR_W-1:0] CHAR_BS         = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_TAB        = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_LF         = 8'h0a;
    localparam logic [CHAR_W-1:0] CHAR_CR         = 8'h0d;
    localparam logic [CHAR_W-1:0] CHAR_SPACE      = 8'h20;
    localparam logic [CHAR_W-1:0] FIRST_PRINTABLE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_EMPTY      = 8'h00;

    localparam int TAB_STOP = 4;
    localparam int TAB_MASK = 3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUT,
        ST_ROWCLR,
        ST_BS,
        ST_RDADDR,
        ST_CLEAR,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

### rtl/tcw_grid_ram.sv
// ============================================================================
// tcw_grid_ram: character cell memory
// Single-port synchronous RAM with one address for reads and writes, registered read data.
// ============================================================================
`default_nettype none

module tcw_grid_ram #(
    parameter int DEPTH = tcw_pkg::GRID_ROWS_DEF * tcw_pkg::GRID_COLS_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                        clk,
    input  wire logic [ADDR_W-1:0]           addr,
    input  wire logic                        we,
    input  wire logic [tcw_pkg::CHAR_W-1:0]  wdata,
    input  wire logic                        re,
    output logic      [tcw_pkg::CHAR_W-1:0]  rdata
);
    import tcw_pkg::*;

    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/text_console_char_writer.sv
// a tab writes one cell per cycle until a wrap; a wrap that scrolls clears the new bottom
// row, one cleared cell per cycle, before the writes go on; a line feed that scrolls clears
// that row the same way; clear zeroes every cell; one item is in flight at a time
// reset: cursor homes, then a clearing pass over every cell zeroes
// the grid with s_tready low
// ============================================================================
// text_console_char_writer: character cell console with write cursor
// Grid kept in one ram addressed through a ring base row, so a scroll only
// advances the base and clears one row.
// ============================================================================
`default_nettype none

module text_console_char_writer #(
    parameter int GRID_ROWS = tcw_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = tcw_pkg::GRID_COLS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // char_in [7:0], read_row [16:8], read_col [24:17], zero fill
    input  wire logic [tcw_pkg::S_TDATA_W-1:0] s_tdata,
    // kind [1:0]
    input  wire logic [tcw_pkg::KIND_W-1:0]    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // read_char [7:0], cursor_row [16:8], cursor_col [24:17], scrolled [25], zero fill
    output logic      [tcw_pkg::M_TDATA_W-1:0] m_tdata
);
    import tcw_pkg::*;

    localparam int DEPTH  = GRID_ROWS * GRID_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ROW_W  = $clog2(GRID_ROWS);
    localparam int COL_W  = $clog2(GRID_COLS);

    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(GRID_ROWS - 1);
    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(GRID_COLS - 1);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);
    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(GRID_COLS);

    function automatic logic [ROW_W-1:0] row_inc(input logic [ROW_W-1:0] r);
        return (r == ROW_LAST) ? '0 : r + 1'b1;
    endfunction

    // input fields
    logic [KIND_W-1:0] in_kind;
    logic [CHAR_W-1:0] in_char;
    logic [RROW_W-1:0] in_row;
    logic [RCOL_W-1:0] in_rcol;

    assign in_kind = s_tuser;
    assign in_char = s_tdata[7:0];
    assign in_row  = s_tdata[16:8];
    assign in_rcol = s_tdata[24:17];

    state_t state_reg, state_next;

    logic [COL_W-1:0]  cur_col_reg,  cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg,  cur_row_next;
    logic [ROW_W-1:0]  cur_prow_reg, cur_prow_next;
    logic [ROW_W-1:0]  base_reg,     base_next;
    logic [CHAR_W-1:0] ch_reg,       ch_next;
    logic [2:0]        cnt_reg,      cnt_next;
    logic              sc_reg,       sc_next;
    logic              rd_hit_reg,   rd_hit_next;
    logic [ROW_W-1:0]  rd_prow_reg,  rd_prow_next;
    logic [COL_W-1:0]  rd_col_reg,   rd_col_next;
    logic [ADDR_W-1:0] sweep_reg,    sweep_next;
    logic [COL_W-1:0]  rc_col_reg,   rc_col_next;
    logic              clr_item_reg, clr_item_next;

    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg;
    logic [RROW_W-1:0] out_row_reg;
    logic [RCOL_W-1:0] out_col_reg;
    logic              out_sc_reg;

    // memory port
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;
    logic              mem_re;
    logic [CHAR_W-1:0] mem_wdata;
    logic [CHAR_W-1:0] mem_rdata;

    logic [ROW_W-1:0]  mul_row;
    logic [COL_W-1:0]  mul_col;
    logic [ADDR_W-1:0] cell_addr;

    // next line values shared by line feed and wrap
    logic              nl_bottom;
    logic [ROW_W-1:0]  nl_row;
    logic [ROW_W-1:0]  nl_prow;
    logic [ROW_W-1:0]  nl_base;

    logic [ROW_W:0]    rd_sum;
    logic [ROW_W-1:0]  rd_prow_calc;
    logic              rd_in_range;

    logic              in_xfer;
    logic              finish;
    logic              out_load;
    logic [CHAR_W-1:0] res_char;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;

    assign nl_bottom = (cur_row_reg == ROW_LAST);
    assign nl_row    = nl_bottom ? cur_row_reg : cur_row_reg + 1'b1;
    assign nl_prow   = row_inc(cur_prow_reg);
    assign nl_base   = nl_bottom ? row_inc(base_reg) : base_reg;

    assign rd_in_range  = (32'(in_row) < 32'(GRID_ROWS)) && (32'(in_rcol) < 32'(GRID_COLS));
    assign rd_sum       = (ROW_W+1)'(in_row) + (ROW_W+1)'(base_reg);
    assign rd_prow_calc = (rd_sum >= (ROW_W+1)'(GRID_ROWS))
                          ? ROW_W'(rd_sum - (ROW_W+1)'(GRID_ROWS)) : ROW_W'(rd_sum);

    // one multiplier shared by cursor writes, row clears and reads
    always_comb
    begin
        if (state_reg == ST_RDADDR)
        begin
            mul_row = rd_prow_reg;
            mul_col = rd_col_reg;
        end
        else if (state_reg == ST_ROWCLR)
        begin
            mul_row = cur_prow_reg;
            mul_col = rc_col_reg;
        end
        else
        begin
            mul_row = cur_prow_reg;
            mul_col = cur_col_reg;
        end
    end

    assign cell_addr = ADDR_W'(mul_row) * COLS_A + ADDR_W'(mul_col);
    assign mem_addr  = (state_reg == ST_CLEAR) ? sweep_reg : cell_addr;

    tcw_grid_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .addr  (mem_addr),
        .we    (mem_we),
        .wdata (mem_wdata),
        .re    (mem_re),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            cur_prow_reg  <= '0;
            base_reg      <= '0;
            cnt_reg       <= '0;
            sc_reg        <= 1'b0;
            rd_hit_reg    <= 1'b0;
            sweep_reg     <= '0;
            rc_col_reg    <= '0;
            clr_item_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            cur_prow_reg  <= cur_prow_next;
            base_reg      <= base_next;
            cnt_reg       <= cnt_next;
            sc_reg        <= sc_next;
            rd_hit_reg    <= rd_hit_next;
            sweep_reg     <= sweep_next;
            rc_col_reg    <= rc_col_next;
            clr_item_reg  <= clr_item_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg      <= ch_next;
        rd_prow_reg <= rd_prow_next;
        rd_col_reg  <= rd_col_next;
        if (out_load)
        begin
            out_char_reg <= res_char;
            out_row_reg  <= RROW_W'(cur_row_next);
            out_col_reg  <= RCOL_W'(cur_col_next);
            out_sc_reg   <= sc_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cur_col_next  = cur_col_reg;
        cur_row_next  = cur_row_reg;
        cur_prow_next = cur_prow_reg;
        base_next     = base_reg;
        ch_next       = ch_reg;
        cnt_next      = cnt_reg;
        sc_next       = sc_reg;
        rd_hit_next   = rd_hit_reg;
        rd_prow_next  = rd_prow_reg;
        rd_col_next   = rd_col_reg;
        sweep_next    = sweep_reg;
        rc_col_next   = rc_col_reg;
        clr_item_next = clr_item_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_wdata     = CHAR_EMPTY;
        finish        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    sc_next       = 1'b0;
                    rd_hit_next   = 1'b0;
                    clr_item_next = 1'b0;
                    state_next    = ST_DONE;
                    unique case (in_kind)
                        KIND_PUT:
                        begin
                            unique case (in_char)
                                CHAR_CR:
                                begin
                                    cur_col_next = '0;
                                end
                                CHAR_LF:
                                begin
                                    cur_col_next  = '0;
                                    cur_row_next  = nl_row;
                                    cur_prow_next = nl_prow;
                                    base_next     = nl_base;
                                    if (nl_bottom)
                                    begin
                                        sc_next     = 1'b1;
                                        cnt_next    = '0;
                                        rc_col_next = '0;
                                        state_next  = ST_ROWCLR;
                                    end
                                end
                                CHAR_TAB:
                                begin
                                    ch_next    = CHAR_SPACE;
                                    cnt_next   = 3'(TAB_STOP - (32'(cur_col_reg) & TAB_MASK));
                                    state_next = ST_PUT;
                                end
                                CHAR_BS:
                                begin
                                    if (cur_col_reg != '0)
                                    begin
                                        cur_col_next = cur_col_reg - 1'b1;
                                        state_next   = ST_BS;
                                    end
                                end
                                default:
                                begin
                                    if (in_char >= FIRST_PRINTABLE)
                                    begin
                                        ch_next    = in_char;
                                        cnt_next   = 3'd1;
                                        state_next = ST_PUT;
                                    end
                                end
                            endcase
                        end
                        KIND_READ:
                        begin
                            if (rd_in_range)
                            begin
                                rd_hit_next  = 1'b1;
                                rd_prow_next = rd_prow_calc;
                                rd_col_next  = COL_W'(in_rcol);
                                state_next   = ST_RDADDR;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            clr_item_next = 1'b1;
                            cur_col_next  = '0;
                            cur_row_next  = '0;
                            cur_prow_next = '0;
                            base_next     = '0;
                            sweep_next    = '0;
                            state_next    = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_PUT:
            begin
                if (cur_col_reg >= COL_LAST)
                begin
                    // wrap before the last column
                    cur_col_next  = '0;
                    cur_row_next  = nl_row;
                    cur_prow_next = nl_prow;
                    base_next     = nl_base;
                    if (nl_bottom)
                    begin
                        sc_next     = 1'b1;
                        rc_col_next = '0;
                        state_next  = ST_ROWCLR;
                    end
                end
                else
                begin
                    mem_we       = 1'b1;
                    mem_wdata    = ch_reg;
                    cur_col_next = cur_col_reg + 1'b1;
                    cnt_next     = cnt_reg - 1'b1;
                    finish       = (cnt_reg == 3'd1);
                end
            end
            ST_ROWCLR:
            begin
                // new bottom row is the old top row in the ring
                mem_we      = 1'b1;
                rc_col_next = rc_col_reg + 1'b1;
                if (rc_col_reg == COL_LAST)
                begin
                    if (cnt_reg != '0)
                    begin
                        state_next = ST_PUT;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
            end
            ST_BS:
            begin
                mem_we = 1'b1;
                finish = 1'b1;
            end
            ST_RDADDR:
            begin
                mem_re     = 1'b1;
                state_next = ST_DONE;
            end
            ST_CLEAR:
            begin
                mem_we     = 1'b1;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == ADDR_LAST)
                begin
                    if (clr_item_reg)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DONE:
            begin
                finish = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_load = finish && (!out_valid_reg || m_tready);
        if (finish)
        begin
            state_next = out_load ? ST_IDLE : ST_DONE;
        end
    end

    assign res_char = rd_hit_reg ? mem_rdata : CHAR_EMPTY;

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_sc_reg, out_col_reg, out_row_reg, out_char_reg};

`ifndef NO_ASSERTIONS
    // physical row always tracks cursor row through the ring base
    a_prow_ring : assert property (@(posedge clk) disable iff (!rst_n)
        (32'(cur_row_reg) + 32'(base_reg) >= 32'(GRID_ROWS))
            ? (32'(cur_prow_reg) == 32'(cur_row_reg) + 32'(base_reg) - 32'(GRID_ROWS))
            : (32'(cur_prow_reg) == 32'(cur_row_reg) + 32'(base_reg)))
        else $error("physical cursor row out of step with ring base");

    // cursor stays inside the grid
    a_cursor_range : assert property (@(posedge clk) disable iff (!rst_n)
        (cur_col_reg <= COL_LAST) && (cur_row_reg <= ROW_LAST))
        else $error("cursor outside grid");

    // a scrolled result always leaves the cursor on the bottom row
    a_scroll_bottom : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[25]) |-> (m_tdata[16:8] == RROW_W'(ROW_LAST)))
        else $error("scroll reported off the bottom row");

    // single ram port: no read and write in the same cycle
    a_ram_port : assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("ram read and write collide");
`endif

endmodule

`default_nettype wire
